// File: rtl/core/urv_pkg.sv
// Package for the URI reference validator: codes, state and result types,
// and the RFC 3986 character class functions. No dependencies.
`default_nettype none

package urv_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int OutPosBits          = 16;

  // Parse phases.
  localparam logic [2:0] PH_SCHEME_FIRST = 3'd0;
  localparam logic [2:0] PH_SCHEME_REST  = 3'd1;
  localparam logic [2:0] PH_AFTER_COLON  = 3'd2;
  localparam logic [2:0] PH_PATH         = 3'd3;
  localparam logic [2:0] PH_AUTH         = 3'd4;
  localparam logic [2:0] PH_QUERY        = 3'd5;
  localparam logic [2:0] PH_FRAG         = 3'd6;
  localparam logic [2:0] PH_DEAD         = 3'd7;

  // Component tags.
  localparam logic [3:0] COMP_SCHEME     = 4'd0;
  localparam logic [3:0] COMP_COLON      = 4'd1;
  localparam logic [3:0] COMP_AUTH_SLASH = 4'd2;
  localparam logic [3:0] COMP_PATH_SLASH = 4'd3;
  localparam logic [3:0] COMP_PATH_CHAR  = 4'd4;
  localparam logic [3:0] COMP_QMARK      = 4'd5;
  localparam logic [3:0] COMP_QUERY      = 4'd6;
  localparam logic [3:0] COMP_HASH       = 4'd7;
  localparam logic [3:0] COMP_FRAGMENT   = 4'd8;
  localparam logic [3:0] COMP_REJECTED   = 4'd9;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_ALPHA_NEEDED = 3'd1;
  localparam logic [2:0] ERR_COLON_NEEDED = 3'd2;
  localparam logic [2:0] ERR_HEX_NEEDED   = 3'd3;
  localparam logic [2:0] ERR_TRAILING     = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG     = 3'd5;

  // Commands.
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Delimiters.
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] hex_owed;
    logic       slash_pending;
    logic       segment_empty;
    logic [2:0] first_error;
  } parse_state_t;

  localparam parse_state_t PARSE_STATE_RESET = '{
    phase: PH_SCHEME_FIRST, hex_owed: 2'd0, slash_pending: 1'b0,
    segment_empty: 1'b1, first_error: ERR_NONE
  };

  typedef struct packed {
    logic [3:0]            component;
    logic                  segment_begin;
    logic [OutPosBits-1:0] byte_position;
    logic                  finished;
    logic [2:0]            error_code;
    logic [OutPosBits-1:0] error_position;
  } result_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_scheme_tail(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == 8'h2B || c == 8'h2D || c == 8'h2E;
  endfunction

  // Unreserved, sub-delims, ':' and '@'.
  function automatic logic is_pchar_plain(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    unique case (c)
      8'h2D, 8'h2E, 8'h5F, 8'h7E,
      8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D,
      8'h3A, 8'h40: hit = 1'b1;
      default:      hit = 1'b0;
    endcase
    return hit || is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_qf_plain(input logic [7:0] c);
    return is_pchar_plain(c) || c == CH_SLASH || c == CH_QMARK;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/urv_in_if.sv
// Input channel of the URI reference validator: valid/ready handshake
// carrying one command and one byte. No dependencies.
`default_nettype none

interface urv_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] byte_value;

  modport source (output valid, command, byte_value, input ready);
  modport sink   (input valid, command, byte_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/urv_out_if.sv
// Result channel of the URI reference validator: valid/ready handshake
// carrying one tagged result per input item. No dependencies.
`default_nettype none

interface urv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  component;
  logic        segment_begin;
  logic [15:0] byte_position;
  logic        finished;
  logic [2:0]  error_code;
  logic [15:0] error_position;

  modport source (output valid, component, segment_begin, byte_position, finished,
                  error_code, error_position, input ready);
  modport sink   (input valid, component, segment_begin, byte_position, finished,
                  error_code, error_position, output ready);
endinterface

`default_nettype wire

// File: rtl/core/urv_classifier.sv
// Combinational next-state and result logic for one transaction of the
// URI reference validator. Depends on urv_pkg.
`default_nettype none

module urv_classifier
  import urv_pkg::*;
#(
  parameter int POSITION_BITS = PositionBitsDefault
) (
  input  parse_state_t             state,
  input  logic [POSITION_BITS-1:0] position_count,
  input  logic [POSITION_BITS-1:0] error_position,
  input  logic                     command,
  input  logic [7:0]               byte_value,
  output parse_state_t             state_next,
  output logic [POSITION_BITS-1:0] position_count_next,
  output logic [POSITION_BITS-1:0] error_position_next,
  output result_t                  result
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  parse_state_t             st;
  logic [3:0]               comp;
  logic                     seg;
  logic                     fin;
  logic                     raise;
  logic [2:0]               raise_code;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] err_pos;
  logic                     path;
  logic [3:0]               qf_comp;
  logic [OutPosBits-1:0]    pos_out;
  logic [OutPosBits-1:0]    err_pos_out;

  always_comb begin
    st         = state;
    comp       = COMP_SCHEME;
    seg        = 1'b0;
    fin        = 1'b0;
    raise      = 1'b0;
    raise_code = ERR_NONE;
    pos        = position_count;
    path       = 1'b0;
    position_count_next = position_count;
    qf_comp    = (state.phase == PH_QUERY) ? COMP_QUERY : COMP_FRAGMENT;

    if (command == CMD_END) begin
      fin = 1'b1;
      if (state.phase == PH_SCHEME_FIRST) begin
        raise = 1'b1; raise_code = ERR_ALPHA_NEEDED;
      end else if (state.phase == PH_SCHEME_REST) begin
        raise = 1'b1; raise_code = ERR_COLON_NEEDED;
      end else if (state.hex_owed != 2'd0) begin
        raise = 1'b1; raise_code = ERR_HEX_NEEDED;
      end
    end else if (position_count == POS_MAX) begin
      raise = 1'b1; raise_code = ERR_TOO_LONG;
      comp  = COMP_REJECTED;
    end else begin
      position_count_next = position_count + POSITION_BITS'(1);
      if (state.phase == PH_DEAD) begin
        comp = COMP_REJECTED;
      end else if (state.hex_owed != 2'd0) begin
        if (!is_hex(byte_value)) begin
          raise = 1'b1; raise_code = ERR_HEX_NEEDED; comp = COMP_REJECTED;
        end else begin
          st.hex_owed = state.hex_owed - 2'd1;
          comp = (state.phase == PH_QUERY) ? COMP_QUERY :
                 (state.phase == PH_FRAG) ? COMP_FRAGMENT : COMP_PATH_CHAR;
        end
      end else begin
        unique case (state.phase)
          PH_SCHEME_FIRST: begin
            if (is_alpha(byte_value)) begin
              st.phase = PH_SCHEME_REST; comp = COMP_SCHEME;
            end else begin
              raise = 1'b1; raise_code = ERR_ALPHA_NEEDED; comp = COMP_REJECTED;
            end
          end
          PH_SCHEME_REST: begin
            if (is_scheme_tail(byte_value)) begin
              comp = COMP_SCHEME;
            end else if (byte_value == CH_COLON) begin
              st.phase = PH_AFTER_COLON; st.segment_empty = 1'b1; comp = COMP_COLON;
            end else begin
              raise = 1'b1; raise_code = ERR_COLON_NEEDED; comp = COMP_REJECTED;
            end
          end
          PH_AFTER_COLON: begin
            st.phase = PH_PATH;
            if (byte_value == CH_SLASH) begin
              st.slash_pending = 1'b1; st.segment_empty = 1'b1;
              comp = COMP_PATH_SLASH;
            end else begin
              path = 1'b1;
            end
          end
          PH_AUTH: begin
            if (byte_value == CH_QMARK) begin
              st.phase = PH_QUERY; comp = COMP_QMARK;
            end else if (byte_value == CH_HASH) begin
              st.phase = PH_FRAG; comp = COMP_HASH;
            end else begin
              raise = 1'b1; raise_code = ERR_TRAILING; comp = COMP_REJECTED;
            end
          end
          PH_QUERY, PH_FRAG: begin
            if (is_qf_plain(byte_value)) begin
              comp = qf_comp;
            end else if (byte_value == CH_PERCENT) begin
              st.hex_owed = 2'd2; comp = qf_comp;
            end else if (state.phase == PH_QUERY && byte_value == CH_HASH) begin
              st.phase = PH_FRAG; comp = COMP_HASH;
            end else begin
              raise = 1'b1; raise_code = ERR_TRAILING; comp = COMP_REJECTED;
            end
          end
          default: path = 1'b1;
        endcase

        if (path) begin
          st.slash_pending = 1'b0;
          if (state.slash_pending && byte_value == CH_SLASH) begin
            st.phase = PH_AUTH; comp = COMP_AUTH_SLASH;
          end else if (byte_value == CH_SLASH) begin
            st.segment_empty = 1'b1; comp = COMP_PATH_SLASH;
          end else if (is_pchar_plain(byte_value) || byte_value == CH_PERCENT) begin
            if (byte_value == CH_PERCENT) begin
              st.hex_owed = 2'd2;
            end
            seg = state.segment_empty;
            st.segment_empty = 1'b0;
            comp = COMP_PATH_CHAR;
          end else if (byte_value == CH_QMARK) begin
            st.phase = PH_QUERY; comp = COMP_QMARK;
          end else if (byte_value == CH_HASH) begin
            st.phase = PH_FRAG; comp = COMP_HASH;
          end else begin
            raise = 1'b1; raise_code = ERR_TRAILING; comp = COMP_REJECTED;
          end
        end
      end
    end

    // Only the first error is kept; any error ends the parse.
    err_pos = error_position;
    if (raise) begin
      if (state.first_error == ERR_NONE) begin
        st.first_error = raise_code;
        err_pos        = pos;
      end
      st.phase         = PH_DEAD;
      st.hex_owed      = 2'd0;
      st.slash_pending = 1'b0;
    end

    // The end item reports, then returns everything to the reset state.
    if (fin) begin
      state_next          = PARSE_STATE_RESET;
      position_count_next = '0;
      error_position_next = '0;
    end else begin
      state_next          = st;
      error_position_next = err_pos;
    end
  end

  // Positions are reported in their low bits.
  if (POSITION_BITS >= OutPosBits) begin : g_pos_trunc
    assign pos_out     = pos[OutPosBits-1:0];
    assign err_pos_out = err_pos[OutPosBits-1:0];
  end else begin : g_pos_extend
    assign pos_out     = {{(OutPosBits-POSITION_BITS){1'b0}}, pos};
    assign err_pos_out = {{(OutPosBits-POSITION_BITS){1'b0}}, err_pos};
  end

  always_comb begin
    result.component      = comp;
    result.segment_begin  = seg;
    result.byte_position  = pos_out;
    result.finished       = fin;
    result.error_code     = st.first_error;
    result.error_position = err_pos_out;
  end

endmodule

`default_nettype wire

// File: rtl/core/uri_reference_validator_core.sv
// Top level of the URI reference validator: parse state registers, the
// classifier, and a two-entry result buffer. Depends on urv_pkg, urv_in_if,
// urv_out_if and urv_classifier.
//
//   Channel   Modport  Payload                                       Role
//   items     sink     command, byte_value                           URI bytes, end item
//   results   source   component, segment_begin, byte_position,      one per item
//                      finished, error_code, error_position
//
// For each transaction on items the classifier updates the parse state in the
// cycle of acceptance, and its result is registered. The result leaves in the
// cycle after acceptance at the earliest, so one item per cycle is sustained
// while results are taken. A skid register behind the output register lets
// one more item be accepted while results stall; items.ready drops only when
// both result registers are full.
// Reset (rst, synchronous) clears the parse state and empties both result
// registers; no clearing pass is needed.
`default_nettype none

module uri_reference_validator_core
  import urv_pkg::*;
#(
  parameter int POSITION_BITS = PositionBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  urv_in_if.sink     items,
  urv_out_if.source  results
);

  // Parse state, updated once per accepted input transaction.
  parse_state_t             state;
  parse_state_t             state_next;
  logic [POSITION_BITS-1:0] position_count;
  logic [POSITION_BITS-1:0] position_count_next;
  logic [POSITION_BITS-1:0] error_position;
  logic [POSITION_BITS-1:0] error_position_next;
  result_t                  step_result;

  // Output register and skid register.
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic in_take;
  logic out_take;

  assign items.ready = !skid_valid;
  assign in_take     = items.valid && items.ready;
  assign out_take    = out_valid && results.ready;

  urv_classifier #(
    .POSITION_BITS (POSITION_BITS)
  ) u_classifier (
    .state               (state),
    .position_count      (position_count),
    .error_position      (error_position),
    .command             (items.command),
    .byte_value          (items.byte_value),
    .state_next          (state_next),
    .position_count_next (position_count_next),
    .error_position_next (error_position_next),
    .result              (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= PARSE_STATE_RESET;
      position_count <= '0;
      error_position <= '0;
    end else if (in_take) begin
      state          <= state_next;
      position_count <= position_count_next;
      error_position <= error_position_next;
    end
  end

  // Results drain from the output register; the skid register refills it.
  // While the skid register is full no input is taken, so the two never
  // load in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (in_take) begin
        out_data <= step_result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid) begin
        out_data  <= step_result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= step_result;
        skid_valid <= 1'b1;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.component      = out_data.component;
  assign results.segment_begin  = out_data.segment_begin;
  assign results.byte_position  = out_data.byte_position;
  assign results.finished       = out_data.finished;
  assign results.error_code     = out_data.error_code;
  assign results.error_position = out_data.error_position;

`ifndef SYNTHESIS
  // The skid register is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // The parse only dies through an error, which is always recorded.
  a_dead_has_error: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_DEAD) |-> (state.first_error != ERR_NONE))
    else $error("parse stopped without a recorded error");

  // Hex digits are owed only inside the path, query or fragment.
  a_hex_owed_phase: assert property (@(posedge clk) disable iff (rst)
    (state.hex_owed != 2'd0) |->
      (state.phase == PH_PATH || state.phase == PH_QUERY || state.phase == PH_FRAG))
    else $error("hex digits owed outside path, query or fragment");

  // An end transaction returns the parser to its reset state.
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_take && items.command == CMD_END) |=>
      (state == PARSE_STATE_RESET && position_count == '0 && error_position == '0))
    else $error("parse state not restarted after end item");
`endif

endmodule

`default_nettype wire
